// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the LED chase sequencer RTL.
// No dependencies; the macros collapse to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks that a property holds at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Checks that an expression is never true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ===== rtl/core/lcps_pkg.sv =====
// Types and constants of the LED chase pattern sequencer.
// No dependencies; used by lcps_step and led_chase_pattern_sequencer_top.
`default_nettype none

package lcps_pkg;

	localparam int ADDR_W  = 8;
	localparam int DELAY_W = 10;
	localparam int PHASE_W = 4;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 10;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LIGHT_COUNT   = 4'd0,
		REG_PATTERN_SEL   = 4'd1,
		REG_SPEED_SEL     = 4'd2,
		REG_SPEED_ONE_MIN = 4'd3,
		REG_SPEED_ONE_MAX = 4'd4,
		REG_SPEED_TWO_MIN = 4'd5,
		REG_SPEED_TWO_MAX = 4'd6,
		REG_DELAY_DEC     = 4'd7
	} reg_index_t;

	localparam logic PAT_SWEEP  = 1'b0;
	localparam logic PAT_CENTRE = 1'b1;

	localparam logic [1:0] SPEED_ONE = 2'd0;
	localparam logic [1:0] SPEED_TWO = 2'd1;

	localparam logic [ADDR_W-1:0]  RST_LIGHT_COUNT   = 8'd16;
	localparam logic               RST_PATTERN_SEL   = PAT_SWEEP;
	localparam logic [1:0]         RST_SPEED_SEL     = SPEED_ONE;
	localparam logic [DELAY_W-1:0] RST_SPEED_ONE_MIN = 10'd20;
	localparam logic [DELAY_W-1:0] RST_SPEED_ONE_MAX = 10'd200;
	localparam logic [DELAY_W-1:0] RST_SPEED_TWO_MIN = 10'd10;
	localparam logic [DELAY_W-1:0] RST_SPEED_TWO_MAX = 10'd100;
	localparam logic [DELAY_W-1:0] RST_DELAY_DEC     = 10'd10;

	typedef struct packed {
		logic [ADDR_W-1:0]  light_count;
		logic               pattern_select;
		logic [1:0]         speed_select;
		logic [DELAY_W-1:0] speed_one_min_ms;
		logic [DELAY_W-1:0] speed_one_max_ms;
		logic [DELAY_W-1:0] speed_two_min_ms;
		logic [DELAY_W-1:0] speed_two_max_ms;
		logic [DELAY_W-1:0] delay_decrement_ms;
	} cfg_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  sweep_position;
		logic [ADDR_W-1:0]  sweep_previous;
		logic [ADDR_W-1:0]  upper_position;
		logic [ADDR_W-1:0]  upper_previous;
		logic [ADDR_W-1:0]  lower_position;
		logic [ADDR_W-1:0]  lower_previous;
		logic               sweep_running;
		logic [PHASE_W-1:0] program_phase;
		logic               half_toggle;
		logic [DELAY_W-1:0] current_delay;
	} state_t;

	// All results of one step: up to four commands, or one idle result.
	typedef struct packed {
		logic                   has_cmd;
		logic [1:0]             last_idx;
		logic [3:0][ADDR_W-1:0] addr;
		logic [3:0]             light_on;
		logic [DELAY_W-1:0]     delay;
	} step_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/lcps_step.sv =====
// Step logic of the LED chase sequencer: next pattern state and the commands of one tick.
// Depends on lcps_pkg.
`default_nettype none

module lcps_step #(
	parameter int FIRST_ADDRESS = 1,
	parameter int SWEEP_REPEATS = 3
) (
	input  lcps_pkg::cfg_t      cfg_i,
	input  lcps_pkg::state_t    state_i,
	output lcps_pkg::state_t    state_o,
	output lcps_pkg::step_res_t res_o
);

	localparam logic [lcps_pkg::ADDR_W-1:0]  FIRST = lcps_pkg::ADDR_W'(FIRST_ADDRESS);
	localparam logic [lcps_pkg::PHASE_W-1:0] REP1  = lcps_pkg::PHASE_W'(SWEEP_REPEATS);
	localparam logic [lcps_pkg::PHASE_W-1:0] REP2  = lcps_pkg::PHASE_W'(2 * SWEEP_REPEATS);
	localparam logic [lcps_pkg::PHASE_W-1:0] REP3  = lcps_pkg::PHASE_W'(3 * SWEEP_REPEATS);

	lcps_pkg::state_t    ns;
	lcps_pkg::step_res_t res;
	logic [lcps_pkg::ADDR_W-1:0]  n;
	logic [lcps_pkg::ADDR_W-1:0]  half_n;
	logic [lcps_pkg::DELAY_W-1:0] lo_lim;
	logic [lcps_pkg::DELAY_W-1:0] hi_lim;
	logic                         do_sweep;
	logic                         go_back;
	logic                         sw_done;
	logic                         use_speed;

	assign n      = cfg_i.light_count;
	assign half_n = n >> 1;

	always_comb begin
		ns        = state_i;
		res       = '0;
		do_sweep  = 1'b0;
		go_back   = 1'b0;
		sw_done   = 1'b0;
		use_speed = 1'b1;
		lo_lim    = cfg_i.speed_one_min_ms;
		hi_lim    = cfg_i.speed_one_max_ms;

		case (cfg_i.speed_select)
			lcps_pkg::SPEED_ONE: begin
				lo_lim = cfg_i.speed_one_min_ms;
				hi_lim = cfg_i.speed_one_max_ms;
			end
			lcps_pkg::SPEED_TWO: begin
				lo_lim = cfg_i.speed_two_min_ms;
				hi_lim = cfg_i.speed_two_max_ms;
			end
			default: use_speed = 1'b0;
		endcase

		if (cfg_i.pattern_select == lcps_pkg::PAT_SWEEP) begin
			if (state_i.program_phase < REP1) begin
				do_sweep = 1'b1;
			end else if (state_i.program_phase < REP2) begin
				do_sweep = 1'b1;
				go_back  = 1'b1;
			end else if (state_i.program_phase < REP3) begin
				do_sweep = 1'b1;
				go_back  = state_i.half_toggle;
			end

			if (do_sweep) begin
				if (!ns.sweep_running) begin
					ns.sweep_running  = 1'b1;
					ns.sweep_position = go_back ? n : FIRST;
					ns.sweep_previous = go_back ? FIRST : n;
				end
				res.has_cmd     = 1'b1;
				res.last_idx    = 2'd1;
				res.addr[0]     = ns.sweep_previous;
				res.light_on[0] = 1'b0;
				res.addr[1]     = ns.sweep_position;
				res.light_on[1] = 1'b1;
				ns.sweep_previous = ns.sweep_position;
				if (!go_back && (ns.sweep_position < n)) begin
					ns.sweep_position = ns.sweep_position + 8'd1;
				end else if (go_back && (ns.sweep_position > FIRST)) begin
					ns.sweep_position = ns.sweep_position - 8'd1;
				end else begin
					ns.sweep_running = 1'b0;
					sw_done          = 1'b1;
				end

				// In the mixed phases a forward pass only flips the half; the
				// following backward pass closes the pair.
				if (sw_done) begin
					if (state_i.program_phase < REP2) begin
						ns.program_phase = state_i.program_phase + 4'd1;
					end else if (!go_back) begin
						ns.half_toggle = 1'b1;
					end else begin
						ns.half_toggle   = 1'b0;
						ns.program_phase = state_i.program_phase + 4'd1;
					end
				end
			end else begin
				ns.program_phase = '0;
				if (use_speed) begin
					if (state_i.current_delay > lo_lim) begin
						if ((state_i.current_delay - lo_lim) < cfg_i.delay_decrement_ms) begin
							ns.current_delay = lo_lim;
						end else begin
							ns.current_delay = state_i.current_delay - cfg_i.delay_decrement_ms;
						end
					end else begin
						ns.current_delay = hi_lim;
					end
				end
			end
		end else begin
			if (!state_i.half_toggle) begin
				if (!ns.sweep_running) begin
					ns.sweep_running  = 1'b1;
					ns.upper_position = half_n + 8'd1;
					ns.upper_previous = n;
					ns.lower_position = half_n;
					ns.lower_previous = FIRST;
				end
			end else begin
				if (!ns.sweep_running) begin
					ns.sweep_running  = 1'b1;
					ns.upper_position = n;
					ns.upper_previous = half_n + 8'd1;
					ns.lower_position = FIRST;
					ns.lower_previous = half_n;
				end
			end

			res.has_cmd     = 1'b1;
			res.last_idx    = 2'd3;
			res.addr[0]     = ns.upper_previous;
			res.light_on[0] = 1'b0;
			res.addr[1]     = ns.lower_previous;
			res.light_on[1] = 1'b0;
			res.addr[2]     = ns.upper_position;
			res.light_on[2] = 1'b1;
			res.addr[3]     = ns.lower_position;
			res.light_on[3] = 1'b1;
			ns.upper_previous = ns.upper_position;
			ns.lower_previous = ns.lower_position;

			if (!state_i.half_toggle) begin
				if (ns.upper_position < n) begin
					ns.upper_position = ns.upper_position + 8'd1;
					ns.lower_position = ns.lower_position - 8'd1;
				end else begin
					ns.half_toggle   = 1'b1;
					ns.sweep_running = 1'b0;
				end
			end else begin
				if (ns.lower_position < half_n) begin
					ns.upper_position = ns.upper_position - 8'd1;
					ns.lower_position = ns.lower_position + 8'd1;
				end else begin
					ns.half_toggle   = 1'b0;
					ns.sweep_running = 1'b0;
				end
			end

			if (use_speed) begin
				ns.current_delay = lo_lim;
			end
		end

		res.delay = ns.current_delay;
	end

	assign state_o = ns;
	assign res_o   = res;

endmodule

`default_nettype wire

// ===== rtl/core/led_chase_pattern_sequencer_top.sv =====
// LED chase pattern sequencer, top level: handshakes, configuration registers,
// pattern state and the result register. Depends on lcps_pkg, lcps_step and
// assert_macros.svh.
//
// Usage:
// - Input channel (in_valid, in_stall, step_tick): one transaction per step
//   tick. A tick of 0 is consumed and yields nothing.
// - Output channel (out_valid, out_stall, result fields): one transaction per
//   result. A tick yields one idle result (command_valid low), two sweep
//   commands or four pair commands; last_of_step marks the final one.
// - Configuration (cfg_valid, cfg_ready, cfg_index, cfg_data): cfg_ready is
//   always high; write only while no tick is in flight.
// Flow: a tick accepted into the input register is loaded into the result
// register once that is free, and its results are handed out from there.
// Throughput: the result register hands out one result per cycle while
// out_stall is low; a tick has 1, 2 or 4 results, and the next tick is
// accepted while the previous results drain.
// Reset clears the channels, restores the register defaults and the pattern
// state. When out_stall is high the current result holds, and in_stall rises
// once the input register also holds a nonzero tick.
`default_nettype none

module led_chase_pattern_sequencer_top #(
	parameter int FIRST_ADDRESS    = 1,
	parameter int SWEEP_REPEATS    = 3,
	parameter int DEFAULT_DELAY_MS = 200
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               step_tick,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               command_valid,
	output logic [lcps_pkg::ADDR_W-1:0]        light_address,
	output logic                               light_on,
	output logic [lcps_pkg::DELAY_W-1:0]       next_delay_ms,
	output logic                               last_of_step,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lcps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lcps_pkg::CFG_DATA_W-1:0]    cfg_data
);

	`include "assert_macros.svh"

	lcps_pkg::cfg_t      cfg_q;
	lcps_pkg::state_t    state_q;
	lcps_pkg::state_t    state_rst;
	lcps_pkg::state_t    state_next;
	lcps_pkg::step_res_t step_res;
	lcps_pkg::step_res_t res_q;

	logic       valid_s1;
	logic       tick_s1;
	logic       res_valid_q;
	logic [1:0] idx_q;
	logic       out_take;
	logic       last_take;
	logic       res_free;
	logic       s1_go;
	logic       load;
	logic       in_take;

	lcps_step #(
		.FIRST_ADDRESS(FIRST_ADDRESS),
		.SWEEP_REPEATS(SWEEP_REPEATS)
	) u_step (
		.cfg_i  (cfg_q),
		.state_i(state_q),
		.state_o(state_next),
		.res_o  (step_res)
	);

	assign cfg_ready = 1'b1;

	assign out_take  = res_valid_q && !out_stall;
	assign last_take = out_take && (idx_q == res_q.last_idx);
	assign res_free  = !res_valid_q || last_take;
	// A zero tick leaves the input register without waiting for the results.
	assign s1_go     = valid_s1 && (!tick_s1 || res_free);
	assign load      = valid_s1 && tick_s1 && res_free;
	assign in_stall  = valid_s1 && !s1_go;
	assign in_take   = in_valid && !in_stall;

	// Pattern state after reset: everything clear except the step delay.
	always_comb begin
		state_rst               = '0;
		state_rst.current_delay = lcps_pkg::DELAY_W'(DEFAULT_DELAY_MS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.light_count        <= lcps_pkg::RST_LIGHT_COUNT;
			cfg_q.pattern_select     <= lcps_pkg::RST_PATTERN_SEL;
			cfg_q.speed_select       <= lcps_pkg::RST_SPEED_SEL;
			cfg_q.speed_one_min_ms   <= lcps_pkg::RST_SPEED_ONE_MIN;
			cfg_q.speed_one_max_ms   <= lcps_pkg::RST_SPEED_ONE_MAX;
			cfg_q.speed_two_min_ms   <= lcps_pkg::RST_SPEED_TWO_MIN;
			cfg_q.speed_two_max_ms   <= lcps_pkg::RST_SPEED_TWO_MAX;
			cfg_q.delay_decrement_ms <= lcps_pkg::RST_DELAY_DEC;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lcps_pkg::REG_LIGHT_COUNT:   cfg_q.light_count        <= cfg_data[7:0];
				lcps_pkg::REG_PATTERN_SEL:   cfg_q.pattern_select     <= cfg_data[0];
				lcps_pkg::REG_SPEED_SEL:     cfg_q.speed_select       <= cfg_data[1:0];
				lcps_pkg::REG_SPEED_ONE_MIN: cfg_q.speed_one_min_ms   <= cfg_data;
				lcps_pkg::REG_SPEED_ONE_MAX: cfg_q.speed_one_max_ms   <= cfg_data;
				lcps_pkg::REG_SPEED_TWO_MIN: cfg_q.speed_two_min_ms   <= cfg_data;
				lcps_pkg::REG_SPEED_TWO_MAX: cfg_q.speed_two_max_ms   <= cfg_data;
				lcps_pkg::REG_DELAY_DEC:     cfg_q.delay_decrement_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= state_rst;
		end else if (load) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			tick_s1 <= step_tick;
		end
		if (load) begin
			res_q <= step_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			res_valid_q <= 1'b1;
			idx_q       <= '0;
		end else if (last_take) begin
			res_valid_q <= 1'b0;
		end else if (out_take) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	assign out_valid     = res_valid_q;
	assign command_valid = res_q.has_cmd;
	assign light_address = res_q.addr[idx_q];
	assign light_on      = res_q.light_on[idx_q];
	assign next_delay_ms = res_q.delay;
	assign last_of_step  = (idx_q == res_q.last_idx);

	`ASSERT_PROP(a_idx_in_range, clk, arst_n, out_valid |-> (idx_q <= res_q.last_idx), "result index past last")
	`ASSERT_NEVER(a_stall_without_item, clk, arst_n, in_stall && !valid_s1, "input stalled while register empty")
	`ASSERT_PROP(a_load_presents, clk, arst_n, load |=> (out_valid && (idx_q == 2'd0)), "loaded step not presented")
	`ASSERT_PROP(a_idle_single, clk, arst_n, (out_valid && !command_valid) |-> last_of_step, "idle step not single")

endmodule

`default_nettype wire
